// ----- rtl/jcfr_pkg.sv -----
// jcfr_pkg: sizes, codes and item types shared by the frame reassembler files
// standalone, no dependencies
`default_nettype none

package jcfr_pkg;

    localparam int FRAME_CHUNKS  = 512;
    localparam int RING_SLOTS    = 4;
    localparam int PAYLOAD_BYTES = 1020;
    localparam int HDR_BYTES     = 4;

    localparam int CHUNK_W  = $clog2(FRAME_CHUNKS);
    localparam int SLOT_W   = $clog2(RING_SLOTS);
    localparam int OFF_W    = $clog2(PAYLOAD_BYTES);
    localparam int POS_W    = $clog2(HDR_BYTES + PAYLOAD_BYTES);
    localparam int TAIL_W   = $clog2(PAYLOAD_BYTES + 1);
    localparam int COUNT_W  = $clog2(FRAME_CHUNKS + 1);
    localparam int FBYTES_W = 19;
    localparam int HCHUNK_W = 15;

    localparam int LAST_POS = HDR_BYTES + PAYLOAD_BYTES - 1;

    localparam logic [7:0] BYTE_FF = 8'hff;
    localparam logic [7:0] BYTE_D9 = 8'hd9;

    typedef enum logic [1:0] {
        MODE_HEADER   = 2'd0,
        MODE_WRITE    = 2'd1,
        MODE_SKIP     = 2'd2,
        MODE_OVERLONG = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DONE      = 3'd1,
        ST_DONE_FULL = 3'd2,
        ST_MISSING   = 3'd3,
        ST_RANGE     = 3'd4,
        ST_BAD_LEN   = 3'd5,
        ST_IGNORED   = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              last_byte;
        logic [SLOT_W-1:0] reader_slot;
    } t_item;

    typedef struct packed {
        logic                write_valid;
        logic [SLOT_W-1:0]   write_slot;
        logic [CHUNK_W-1:0]  write_chunk;
        logic [OFF_W-1:0]    write_offset;
        logic [7:0]          write_data;
        logic                status_valid;
        t_status             status;
        logic [SLOT_W-1:0]   frame_slot;
        logic [FBYTES_W-1:0] frame_bytes;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/jcfr_ram.sv -----
// jcfr_ram: generic simple dual-port ram, one write port, one registered read port
// standalone, no dependencies
`default_nettype none

module jcfr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/jcfr_core.sv -----
// jcfr_core: datagram parser and frame state, one byte per step, chunk bitmap in ram
// depends on jcfr_pkg and jcfr_ram
`default_nettype none

module jcfr_core
    import jcfr_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_step,
    input  t_item   i_item,
    output t_result o_result
);

    logic                r_in_frame,   n_in_frame;
    logic [COUNT_W-1:0]  r_count,      n_count;
    logic [POS_W-1:0]    r_pos,        n_pos;
    logic [7:0]          r_hh,         n_hh;
    logic [7:0]          r_hl,         n_hl;
    t_mode               r_mode,       n_mode;
    logic [SLOT_W-1:0]   r_slot,       n_slot;
    logic                r_prev_ff,    n_prev_ff;
    logic                r_found,      n_found;
    logic [TAIL_W-1:0]   r_tail,       n_tail;
    logic                r_sweep,      n_sweep;
    logic [CHUNK_W-1:0]  r_sweep_addr, n_sweep_addr;

    logic                seen;
    logic                seen_we;
    logic                ram_we;
    logic [CHUNK_W-1:0]  ram_waddr;
    logic                ram_wdata;
    logic                frame_start;
    t_result             res;

    // bitmap read runs every cycle at the current header chunk; the header
    // is stable for the whole payload, so the data is fresh by the last byte
    jcfr_ram #(
        .WIDTH (1),
        .DEPTH (FRAME_CHUNKS)
    ) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (CHUNK_W'({r_hh[6:0], r_hl})),
        .o_rdata (seen)
    );

    // clearing sweep after a frame opens; entry 0 is written as seen
    always_comb begin
        if (r_sweep) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep_addr;
            ram_wdata = (r_sweep_addr == '0);
        end else begin
            ram_we    = seen_we;
            ram_waddr = CHUNK_W'({n_hh[6:0], n_hl});
            ram_wdata = 1'b1;
        end
        n_sweep      = r_sweep;
        n_sweep_addr = r_sweep_addr;
        if (r_sweep) begin
            n_sweep_addr = r_sweep_addr + 1'b1;
            if (r_sweep_addr == CHUNK_W'(FRAME_CHUNKS - 1)) begin
                n_sweep = 1'b0;
            end
        end
        if (frame_start) begin
            n_sweep      = 1'b1;
            n_sweep_addr = '0;
        end
    end

    always_comb begin
        logic [HCHUNK_W-1:0] hchunk;
        logic [CHUNK_W-1:0]  ch;
        logic [OFF_W-1:0]    off;
        logic                hdr_zero;
        logic [COUNT_W-1:0]  cnt;
        logic [SLOT_W-1:0]   adv;

        n_in_frame  = r_in_frame;
        n_count     = r_count;
        n_pos       = r_pos;
        n_hh        = r_hh;
        n_hl        = r_hl;
        n_mode      = r_mode;
        n_slot      = r_slot;
        n_prev_ff   = r_prev_ff;
        n_found     = r_found;
        n_tail      = r_tail;
        seen_we     = 1'b0;
        frame_start = 1'b0;
        res         = '0;
        hchunk      = '0;
        ch          = '0;
        off         = '0;
        hdr_zero    = 1'b0;
        cnt         = '0;
        adv         = '0;

        if (i_step) begin
            // header capture and payload scan
            if (r_mode != MODE_OVERLONG) begin
                if (r_pos < POS_W'(HDR_BYTES)) begin
                    if (r_pos == POS_W'(2)) begin
                        n_hh = i_item.data_byte;
                    end
                    if (r_pos == POS_W'(3)) begin
                        n_hl   = i_item.data_byte;
                        hchunk = {r_hh[6:0], i_item.data_byte};
                        if (r_hh == 8'h00 && i_item.data_byte == 8'h00) begin
                            n_mode = r_in_frame ? MODE_SKIP : MODE_WRITE;
                        end else if (r_in_frame && hchunk < HCHUNK_W'(FRAME_CHUNKS)) begin
                            n_mode = MODE_WRITE;
                        end else begin
                            n_mode = MODE_SKIP;
                        end
                    end
                end else begin
                    off = OFF_W'(r_pos - POS_W'(HDR_BYTES));
                    if (r_mode == MODE_WRITE) begin
                        res.write_valid  = 1'b1;
                        res.write_slot   = r_slot;
                        res.write_chunk  = CHUNK_W'({r_hh[6:0], r_hl});
                        res.write_offset = off;
                        res.write_data   = i_item.data_byte;
                    end
                    if (r_prev_ff && i_item.data_byte == BYTE_D9 && !r_found) begin
                        n_found = 1'b1;
                        n_tail  = TAIL_W'(off) + 1'b1;
                    end
                    n_prev_ff = (i_item.data_byte == BYTE_FF);
                end
            end

            if (!i_item.last_byte) begin
                if (r_mode != MODE_OVERLONG) begin
                    if (r_pos >= POS_W'(LAST_POS)) begin
                        n_mode = MODE_OVERLONG;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end else begin
                res.status_valid = 1'b1;
                hchunk   = {n_hh[6:0], n_hl};
                ch       = CHUNK_W'(hchunk);
                hdr_zero = (n_hh == 8'h00) && (n_hl == 8'h00);
                if (r_mode == MODE_OVERLONG || r_pos != POS_W'(LAST_POS)) begin
                    res.status = ST_BAD_LEN;
                end else if (hdr_zero) begin
                    if (!r_in_frame) begin
                        n_in_frame  = 1'b1;
                        n_count     = COUNT_W'(1);
                        frame_start = 1'b1;
                        res.status  = ST_STORED;
                    end else begin
                        res.status = ST_IGNORED;
                    end
                end else if (!r_in_frame) begin
                    res.status = ST_IGNORED;
                end else if (hchunk >= HCHUNK_W'(FRAME_CHUNKS)) begin
                    n_in_frame = 1'b0;
                    res.status = ST_RANGE;
                end else begin
                    cnt     = r_count + COUNT_W'(!seen);
                    n_count = cnt;
                    seen_we = !seen;
                    if (n_hh[7]) begin
                        n_in_frame = 1'b0;
                        if (cnt == COUNT_W'(ch) + 1'b1) begin
                            adv = (r_slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : r_slot + 1'b1;
                            n_slot          = adv;
                            res.frame_slot  = r_slot;
                            res.frame_bytes = FBYTES_W'(ch) * FBYTES_W'(PAYLOAD_BYTES)
                                            + FBYTES_W'(n_tail);
                            res.status      = (adv == i_item.reader_slot) ? ST_DONE_FULL
                                                                          : ST_DONE;
                        end else begin
                            res.status = ST_MISSING;
                        end
                    end else begin
                        res.status = ST_STORED;
                    end
                end
                n_pos     = '0;
                n_mode    = MODE_HEADER;
                n_prev_ff = 1'b0;
                n_found   = 1'b0;
                n_tail    = TAIL_W'(PAYLOAD_BYTES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_count      <= '0;
            r_pos        <= '0;
            r_hh         <= '0;
            r_hl         <= '0;
            r_mode       <= MODE_HEADER;
            r_slot       <= '0;
            r_prev_ff    <= 1'b0;
            r_found      <= 1'b0;
            r_tail       <= TAIL_W'(PAYLOAD_BYTES);
            r_sweep      <= 1'b0;
            r_sweep_addr <= '0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_count      <= n_count;
            r_pos        <= n_pos;
            r_hh         <= n_hh;
            r_hl         <= n_hl;
            r_mode       <= n_mode;
            r_slot       <= n_slot;
            r_prev_ff    <= n_prev_ff;
            r_found      <= n_found;
            r_tail       <= n_tail;
            r_sweep      <= n_sweep;
            r_sweep_addr <= n_sweep_addr;
        end
    end

    assign o_result = res;

endmodule

`default_nettype wire

// ----- rtl/jpeg_chunk_frame_reassembler.sv -----
// jpeg_chunk_frame_reassembler: top level, input register, byte core, result register
// depends on jcfr_pkg and jcfr_core
`default_nettype none

// Takes one datagram byte per item and gives one result item per byte, at a
// sustained rate of one item per clock cycle while the result channel is not
// stalled; an item passes through the input register and then the result
// register before its result is offered on the result ports. While a result
// waits under stall the input register takes one more item and then the input
// stalls until the result moves on. Each datagram is a 4-byte header then a
// payload; payload bytes of an open frame come out as ring writes at (slot,
// chunk, offset), and the last byte of each datagram carries a status. The
// received-chunk bitmap sits in a 512-entry ram; when a frame opens, a clearing
// sweep over every entry runs in the background, which always ends before the
// next full-length datagram can look at the bitmap, so the input is never held
// for it.

module jpeg_chunk_frame_reassembler
    import jcfr_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire  [7:0]           i_data_byte,
    input  wire                  i_last_byte,
    input  wire  [SLOT_W-1:0]    i_reader_slot,
    // result channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_write_valid,
    output logic [SLOT_W-1:0]    o_write_slot,
    output logic [CHUNK_W-1:0]   o_write_chunk,
    output logic [OFF_W-1:0]     o_write_offset,
    output logic [7:0]           o_write_data,
    output logic                 o_status_valid,
    output logic [2:0]           o_status,
    output logic [SLOT_W-1:0]    o_frame_slot,
    output logic [FBYTES_W-1:0]  o_frame_bytes
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    logic    advance;
    logic    in_accept;

    // the held item moves on when the result register is empty or being taken
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= '{data_byte: i_data_byte, last_byte: i_last_byte,
                      reader_slot: i_reader_slot};
        end
    end

    // all per-byte work and frame state
    jcfr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_valid  = r_out.write_valid;
    assign o_write_slot   = r_out.write_slot;
    assign o_write_chunk  = r_out.write_chunk;
    assign o_write_offset = r_out.write_offset;
    assign o_write_data   = r_out.write_data;
    assign o_status_valid = r_out.status_valid;
    assign o_status       = r_out.status;
    assign o_frame_slot   = r_out.frame_slot;
    assign o_frame_bytes  = r_out.frame_bytes;

endmodule

`default_nettype wire

// ----- rtl/jcfr_checker.sv -----
// jcfr_checker: port-level checks on the result channel of the reassembler
// depends on jcfr_pkg; bound to jpeg_chunk_frame_reassembler
`default_nettype none

module jcfr_checker
    import jcfr_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire                 o_write_valid,
    input wire [OFF_W-1:0]     o_write_offset,
    input wire [7:0]           o_write_data,
    input wire                 o_status_valid,
    input wire [2:0]           o_status,
    input wire [FBYTES_W-1:0]  o_frame_bytes
);

    // no status fields without a datagram end
    a_status_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status_valid |-> o_status == ST_STORED && o_frame_bytes == '0)
        else $error("status fields set off a datagram end");

    // ring writes stay inside one chunk payload
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_valid |-> o_write_offset < OFF_W'(PAYLOAD_BYTES))
        else $error("write offset beyond payload");

    // a finished frame has a length, other statuses none
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_valid && o_status != ST_DONE && o_status != ST_DONE_FULL
        |-> o_frame_bytes == '0)
        else $error("frame length on a status without a finished frame");

    // a stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_write_data)
                                       && $stable(o_status))
        else $error("stalled result item changed");

endmodule

bind jpeg_chunk_frame_reassembler jcfr_checker u_jcfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_write_valid  (o_write_valid),
    .o_write_offset (o_write_offset),
    .o_write_data   (o_write_data),
    .o_status_valid (o_status_valid),
    .o_status       (o_status),
    .o_frame_bytes  (o_frame_bytes)
);

`default_nettype wire
